FILE: sv/mpdb_pkg.sv
package mpdb_pkg;

  localparam int NUM_PINS = 8;
  localparam int LVL_W    = 8;
  localparam int CNT_W    = 8;
  localparam int THR_W    = NUM_PINS * CNT_W;
  localparam int CFG_W    = 64;
  localparam int CMD_W    = 3;
  localparam int IDX_W    = 3;

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CFG_W-1:0] THR_RESET = 64'h0303_0303_0303_0303;

  typedef enum logic [CMD_W-1:0] {
    CMD_SCAN    = 3'd0,
    CMD_EN_PIN  = 3'd1,
    CMD_DIS_PIN = 3'd2,
    CMD_EN_ALL  = 3'd3,
    CMD_DIS_ALL = 3'd4
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic             stable_bit;
    logic             pend_bit;
    logic             flag;
    logic [CNT_W-1:0] count;
    logic             changed;
  } lane_res_t;

  typedef struct packed {
    logic [NUM_PINS-1:0] stable;
    logic [NUM_PINS-1:0] pend;
    logic [NUM_PINS-1:0] flag;
    logic [NUM_PINS-1:0] changed;
    logic                stopped;
  } scan_nxt_t;

endpackage

FILE: sv/mpdb_if.sv
interface mpdb_in_if;
  logic                         valid;
  logic                         ready;
  logic [mpdb_pkg::CMD_W-1:0]   command;
  logic [mpdb_pkg::IDX_W-1:0]   pin_index;
  logic [mpdb_pkg::LVL_W-1:0]   pin_levels;

  modport source (output valid, command, pin_index, pin_levels, input ready);
  modport sink   (input valid, command, pin_index, pin_levels, output ready);
endinterface

interface mpdb_out_if;
  logic                         valid;
  logic                         ready;
  logic [mpdb_pkg::LVL_W-1:0]   stable_levels;
  logic [mpdb_pkg::LVL_W-1:0]   changed_pins;
  logic                         stopped_early;

  modport source (output valid, stable_levels, changed_pins, stopped_early, input ready);
  modport sink   (input valid, stable_levels, changed_pins, stopped_early, output ready);
endinterface

interface mpdb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mpdb_pkg::CFG_W-1:0]   filter_thresholds;

  modport source (output valid, filter_thresholds, input ready);
  modport sink   (input valid, filter_thresholds, output ready);
endinterface

FILE: sv/mpdb_lane.sv
module mpdb_lane (
  input  logic                         en,
  input  logic                         sample,
  input  logic                         stable,
  input  logic                         pend,
  input  logic                         flag,
  input  logic [mpdb_pkg::CNT_W-1:0]   count,
  input  logic [mpdb_pkg::CNT_W-1:0]   thr,
  output mpdb_pkg::lane_res_t          res
);
  import mpdb_pkg::*;

  logic             diff;
  logic             match;
  logic [CNT_W-1:0] cnt_step;
  logic             accept;

  always_comb begin
    diff     = en && (sample != stable);
    match    = (sample == pend);
    cnt_step = match ? ((count == CNT_MAX) ? count : count + 1'b1) : '0;
    accept   = diff && flag && (cnt_step >= thr);

    res.start      = diff && !flag;
    res.stable_bit = stable;
    res.pend_bit   = pend;
    res.flag       = flag;
    res.count      = count;
    res.changed    = 1'b0;

    if (diff && !flag) begin
      res.pend_bit = sample;
      res.flag     = 1'b1;
      res.count    = '0;
    end else if (diff) begin
      if (accept) begin
        res.stable_bit = pend;
        res.flag       = 1'b0;
        res.count      = '0;
        res.changed    = 1'b1;
      end else begin
        res.flag  = match;
        res.count = cnt_step;
      end
    end
  end

endmodule

FILE: sv/mpdb_merge.sv
module mpdb_merge (
  input  mpdb_pkg::lane_res_t                  lane_res [mpdb_pkg::NUM_PINS],
  input  logic [mpdb_pkg::NUM_PINS-1:0]        stable_cur,
  input  logic [mpdb_pkg::NUM_PINS-1:0]        pend_cur,
  input  logic [mpdb_pkg::NUM_PINS-1:0]        flag_cur,
  input  logic [mpdb_pkg::CNT_W-1:0]           cnt_cur [mpdb_pkg::NUM_PINS],
  output mpdb_pkg::scan_nxt_t                  scan_nxt,
  output logic [mpdb_pkg::CNT_W-1:0]           cnt_nxt [mpdb_pkg::NUM_PINS]
);
  import mpdb_pkg::*;

  logic [NUM_PINS-1:0] start_below;

  // A lane takes part only if no lower pin began pending on this tick.
  always_comb begin
    start_below[0] = 1'b0;
    for (int i = 1; i < NUM_PINS; i++) begin
      start_below[i] = start_below[i-1] || lane_res[i-1].start;
    end
  end

  always_comb begin
    scan_nxt.stopped = 1'b0;
    for (int i = 0; i < NUM_PINS; i++) begin
      if (!start_below[i]) begin
        scan_nxt.stable[i]  = lane_res[i].stable_bit;
        scan_nxt.pend[i]    = lane_res[i].pend_bit;
        scan_nxt.flag[i]    = lane_res[i].flag;
        scan_nxt.changed[i] = lane_res[i].changed;
        cnt_nxt[i]          = lane_res[i].count;
        scan_nxt.stopped    = scan_nxt.stopped || lane_res[i].start;
      end else begin
        scan_nxt.stable[i]  = stable_cur[i];
        scan_nxt.pend[i]    = pend_cur[i];
        scan_nxt.flag[i]    = flag_cur[i];
        scan_nxt.changed[i] = 1'b0;
        cnt_nxt[i]          = cnt_cur[i];
      end
    end
  end

endmodule

FILE: sv/multi_pin_debounce_scanner_core.sv
// Channel  Direction  Payload                                        Accepted when
// in_ch    sink       command, pin_index, pin_levels                 valid && ready
// out_ch   source     stable_levels, changed_pins, stopped_early     valid && ready
// cfg_ch   sink       filter_thresholds                              valid && ready
//
// Every transaction is handled combinationally by the per-pin lanes, and its result
// appears in the output register on the next cycle; one transaction per cycle unless out_ch stalls.
// The input is ready whenever the output register is empty or being drained.
// The configuration port is always ready.
// Reset is synchronous and active low; it clears all pin state and loads the
// default thresholds.
module multi_pin_debounce_scanner_core (
  input  logic        clk,
  input  logic        rst_n,
  mpdb_in_if.sink     in_ch,
  mpdb_out_if.source  out_ch,
  mpdb_cfg_if.sink    cfg_ch
);
  import mpdb_pkg::*;

  logic [NUM_PINS-1:0] en_r;
  logic [NUM_PINS-1:0] stable_r;
  logic [NUM_PINS-1:0] pend_r;
  logic [NUM_PINS-1:0] flag_r;
  logic [CNT_W-1:0]    cnt_r [NUM_PINS];
  logic [CFG_W-1:0]    thr_r;

  logic                out_valid_r;
  logic [LVL_W-1:0]    out_stable_r;
  logic [LVL_W-1:0]    out_changed_r;
  logic                out_stopped_r;

  lane_res_t           lane_res [NUM_PINS];
  scan_nxt_t           scan_nxt;
  logic [CNT_W-1:0]    cnt_scan [NUM_PINS];

  logic [NUM_PINS-1:0] en_nxt;
  logic [NUM_PINS-1:0] stable_nxt;
  logic [NUM_PINS-1:0] pend_nxt;
  logic [NUM_PINS-1:0] flag_nxt;
  logic [CNT_W-1:0]    cnt_nxt [NUM_PINS];
  logic [NUM_PINS-1:0] changed_nxt;
  logic                stopped_nxt;
  logic [NUM_PINS-1:0] pin_bit;
  logic                pin_ok;
  logic                in_fire;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.stable_levels = out_stable_r;
  assign out_ch.changed_pins  = out_changed_r;
  assign out_ch.stopped_early = out_stopped_r;

  for (genvar i = 0; i < NUM_PINS; i++) begin : g_lane
    mpdb_lane u_lane (
      .en     (en_r[i]),
      .sample (in_ch.pin_levels[i]),
      .stable (stable_r[i]),
      .pend   (pend_r[i]),
      .flag   (flag_r[i]),
      .count  (cnt_r[i]),
      .thr    (thr_r[i*CNT_W +: CNT_W]),
      .res    (lane_res[i])
    );
  end

  mpdb_merge u_merge (
    .lane_res   (lane_res),
    .stable_cur (stable_r),
    .pend_cur   (pend_r),
    .flag_cur   (flag_r),
    .cnt_cur    (cnt_r),
    .scan_nxt   (scan_nxt),
    .cnt_nxt    (cnt_scan)
  );

  always_comb begin
    pin_ok      = int'(in_ch.pin_index) < NUM_PINS;
    pin_bit     = pin_ok ? NUM_PINS'(1) << in_ch.pin_index : '0;
    en_nxt      = en_r;
    stable_nxt  = stable_r;
    pend_nxt    = pend_r;
    flag_nxt    = flag_r;
    cnt_nxt     = cnt_r;
    changed_nxt = '0;
    stopped_nxt = 1'b0;
    unique case (cmd_t'(in_ch.command))
      CMD_SCAN: begin
        stable_nxt  = scan_nxt.stable;
        pend_nxt    = scan_nxt.pend;
        flag_nxt    = scan_nxt.flag;
        cnt_nxt     = cnt_scan;
        changed_nxt = scan_nxt.changed;
        stopped_nxt = scan_nxt.stopped;
      end
      CMD_EN_PIN: begin
        en_nxt   = en_r | pin_bit;
        flag_nxt = flag_r & ~pin_bit;
      end
      CMD_DIS_PIN: begin
        en_nxt   = en_r & ~pin_bit;
        flag_nxt = flag_r & ~pin_bit;
      end
      CMD_EN_ALL:  en_nxt = '1;
      CMD_DIS_ALL: en_nxt = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= '0;
      stable_r    <= '0;
      pend_r      <= '0;
      flag_r      <= '0;
      cnt_r       <= '{default: '0};
      thr_r       <= THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        thr_r <= cfg_ch.filter_thresholds;
      end
      if (in_fire) begin
        en_r          <= en_nxt;
        stable_r      <= stable_nxt;
        pend_r        <= pend_nxt;
        flag_r        <= flag_nxt;
        cnt_r         <= cnt_nxt;
        out_stable_r  <= LVL_W'(stable_nxt);
        out_changed_r <= LVL_W'(changed_nxt);
        out_stopped_r <= stopped_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_pend_differs: assert property (@(posedge clk) disable iff (!rst_n)
    (flag_r & ~(pend_r ^ stable_r)) == '0)
    else $error("pending pin holds its stable level");

  a_non_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.command != CMD_SCAN) |=> (out_changed_r == '0) && !out_stopped_r)
    else $error("non-scan transaction reported a change");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while result is stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transaction produced no result");

endmodule

FILE: tb/multi_pin_debounce_scanner_core_tb.sv
`timescale 1ns / 100ps

import mpdb_pkg::*;

localparam logic [LVL_W-1:0] ALL_PINS = LVL_W'((1 << NUM_PINS) - 1);

typedef struct packed {
  logic [LVL_W-1:0] stable_levels;
  logic [LVL_W-1:0] changed_pins;
  logic             stopped_early;
} debounce_result_t;

// Keeps a private copy of the pin state, predicts the result of every accepted
// transaction and compares each returned result with the oldest prediction.
class debounce_scoreboard;
  logic [CFG_W-1:0] thresholds;
  logic [LVL_W-1:0] enabled;
  logic [LVL_W-1:0] stable;
  logic [LVL_W-1:0] pend_level;
  logic [LVL_W-1:0] pend_flag;
  logic [CNT_W-1:0] settle[NUM_PINS];
  debounce_result_t expected_q[$];
  int               mismatches;
  int               items_seen;
  int               changes_seen;
  int               early_stops;

  function new();
    thresholds = THR_RESET;
    enabled    = '0;
    stable     = '0;
    pend_level = '0;
    pend_flag  = '0;
    foreach (settle[i]) settle[i] = '0;
    mismatches   = 0;
    items_seen   = 0;
    changes_seen = 0;
    early_stops  = 0;
  endfunction

  function void write_thresholds(logic [CFG_W-1:0] value);
    thresholds = value;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_input(cmd_t cmd, logic [IDX_W-1:0] pin, logic [LVL_W-1:0] levels);
    debounce_result_t res;
    logic [LVL_W-1:0] lane;
    logic [LVL_W-1:0] sample;
    logic [LVL_W-1:0] pin_bit;
    res = '0;
    pin_bit = LVL_W'(1) << pin;
    case (cmd)
      CMD_SCAN: begin
        for (int i = 0; i < NUM_PINS; i++) begin
          lane   = LVL_W'(1) << i;
          sample = levels & lane;
          if ((enabled & lane) == '0) continue;
          if (sample == (stable & lane)) continue;
          if ((pend_flag & lane) == '0) begin
            pend_level = (pend_level & ~lane) | sample;
            settle[i]  = '0;
            pend_flag |= lane;
            res.stopped_early = 1'b1;
            break;
          end
          if (sample == (pend_level & lane)) begin
            if (settle[i] != CNT_MAX) settle[i] = settle[i] + 1'b1;
          end else begin
            settle[i]  = '0;
            pend_flag &= ~lane;
          end
          if (settle[i] >= thresholds[i*CNT_W +: CNT_W]) begin
            stable     = (stable & ~lane) | (pend_level & lane);
            settle[i]  = '0;
            pend_flag &= ~lane;
            res.changed_pins |= lane;
          end
        end
      end
      CMD_EN_PIN: begin
        if (pin < NUM_PINS) begin
          enabled   |= pin_bit;
          pend_flag &= ~pin_bit;
        end
      end
      CMD_DIS_PIN: begin
        if (pin < NUM_PINS) begin
          enabled   &= ~pin_bit;
          pend_flag &= ~pin_bit;
        end
      end
      CMD_EN_ALL:  enabled = ALL_PINS;
      CMD_DIS_ALL: enabled = '0;
      default: ;
    endcase
    res.stable_levels = stable & ALL_PINS;
    res.changed_pins  = res.changed_pins & ALL_PINS;
    items_seen++;
    changes_seen += $countones(res.changed_pins);
    if (res.stopped_early) early_stops++;
    expected_q.push_back(res);
  endfunction

  function void check_result(logic [LVL_W-1:0] st, logic [LVL_W-1:0] ch, logic stop);
    debounce_result_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with nothing expected: stable=%h changed=%h stopped=%b",
                 $realtime, st, ch, stop);
      return;
    end
    want = expected_q.pop_front();
    if (st !== want.stable_levels || ch !== want.changed_pins || stop !== want.stopped_early)
    begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch: expected stable=%h changed=%h stopped=%b, got %h %h %b",
                 $realtime, want.stable_levels, want.changed_pins, want.stopped_early,
                 st, ch, stop);
    end
  endfunction
endclass

module multi_pin_debounce_scanner_core_tb;
  logic clk;
  logic rst_n;
  bit   bursty;
  int   settings_used;

  mpdb_in_if  in_ch();
  mpdb_out_if out_ch();
  mpdb_cfg_if cfg_ch();

  debounce_scoreboard board;

  multi_pin_debounce_scanner_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (bursty || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random back-pressure, and every accepted transaction is checked.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        board.check_result(out_ch.stable_levels, out_ch.changed_pins, out_ch.stopped_early);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_item(cmd_t cmd, logic [IDX_W-1:0] pin, logic [LVL_W-1:0] levels);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.pin_index  <= pin;
    in_ch.pin_levels <= levels;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    board.note_input(cmd, pin, levels);
  endtask

  task automatic scan(logic [LVL_W-1:0] levels);
    send_item(CMD_SCAN, IDX_W'($urandom_range(0, 7)), levels);
  endtask

  task automatic command_item(cmd_t cmd, logic [IDX_W-1:0] pin);
    send_item(cmd, pin, LVL_W'($urandom_range(0, 255)));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_thresholds(logic [CFG_W-1:0] value);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.filter_thresholds <= value;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    board.write_thresholds(value);
    settings_used++;
  endtask

  function automatic logic [CFG_W-1:0] short_thresholds();
    logic [CFG_W-1:0] value;
    for (int i = 0; i < NUM_PINS; i++) value[i*CNT_W +: CNT_W] = CNT_W'($urandom_range(0, 6));
    return value;
  endfunction

  task automatic directed_items();
    scan(8'hFF);
    command_item(CMD_EN_PIN, 3'd0);
    command_item(CMD_EN_PIN, 3'd7);
    repeat (5) scan(8'hFF);
    command_item(CMD_EN_ALL, 3'd0);
    scan(8'h00);
    scan(8'hFF);
    repeat (4) scan(8'h00);
    command_item(CMD_DIS_PIN, 3'd3);
    command_item(CMD_EN_PIN, 3'd3);
    repeat (3) scan(8'hAA);
    command_item(CMD_DIS_ALL, 3'd5);
    scan(8'h55);
    command_item(CMD_EN_ALL, 3'd2);
    repeat (2) scan(8'h55);
  endtask

  // Mostly held pin patterns that change now and then, with glitches and
  // occasional enable and disable commands mixed in.
  task automatic random_items(int count);
    logic [LVL_W-1:0] target;
    int hold;
    int r;
    target = board.stable;
    hold   = 0;
    for (int k = 0; k < count; k++) begin
      if (k % 64 == 0) bursty = ($urandom_range(0, 2) == 0);
      if (k == count / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        command_item(CMD_EN_PIN, IDX_W'($urandom_range(0, 7)));
      end else if (r < 12) begin
        command_item(CMD_DIS_PIN, IDX_W'($urandom_range(0, 7)));
      end else if (r < 15) begin
        command_item(CMD_EN_ALL, IDX_W'($urandom_range(0, 7)));
      end else if (r < 16) begin
        command_item(CMD_DIS_ALL, IDX_W'($urandom_range(0, 7)));
      end else begin
        if (hold == 0) begin
          target ^= LVL_W'($urandom_range(0, 255));
          hold = $urandom_range(2, 25);
        end
        hold--;
        r = $urandom_range(0, 19);
        if (r == 0)
          scan(LVL_W'($urandom_range(0, 255)));
        else if (r == 1)
          scan(target ^ (LVL_W'(1) << $urandom_range(0, 7)));
        else
          scan(target);
      end
    end
    bursty = 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] setting;
    board         = new();
    bursty        = 1'b0;
    settings_used = 1;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_SCAN;
    in_ch.pin_index   = '0;
    in_ch.pin_levels  = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.filter_thresholds = THR_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    directed_items();
    random_items(190);
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: setting = '0;
        1: setting = short_thresholds();
        2: setting = '1;
        3: setting = 64'h0101_0101_0101_0101;
        4: setting = {$urandom(), $urandom()};
        default: setting = short_thresholds();
      endcase
      write_thresholds(setting);
      random_items(190);
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (board.pending() != 0)
      $display("%0d expected results never arrived", board.pending());
    $display("Ran %0d transactions under %0d threshold settings.",
             board.items_seen, settings_used);
    $display("Saw %0d accepted pin changes and %0d scans cut short by a new pending pin.",
             board.changes_seen, board.early_stops);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

FILE: multi_pin_debounce_scanner_core.f
sv/mpdb_pkg.sv
sv/mpdb_if.sv
sv/mpdb_lane.sv
sv/mpdb_merge.sv
sv/multi_pin_debounce_scanner_core.sv
tb/multi_pin_debounce_scanner_core_tb.sv
